// ----- rtl/core/gto_pkg.sv -----
// ============================================================================
// gto_pkg
// Shared sizes, status codes and command types for the graph traversal block.
// ============================================================================
package gto_pkg;

  localparam int unsigned NodesDefault = 64;
  localparam int unsigned LinksDefault = 512;
  localparam int unsigned NodeW = 6;

  localparam logic [1:0] StatusVisit = 2'd0;
  localparam logic [1:0] StatusAdded = 2'd1;
  localparam logic [1:0] StatusDrop  = 2'd2;

  localparam logic [1:0] ModeDepth   = 2'd0;
  localparam logic [1:0] ModeStack   = 2'd1;
  localparam logic [1:0] ModeBreadth = 2'd2;

  localparam logic KindEdge = 1'b0;
  localparam logic KindWalk = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,
    OpEdgeHead,
    OpEdgeWrite,
    OpEdgeLink,
    OpClearMarks,
    OpWalkStart,
    OpPop,
    OpHeadRead,
    OpLinkRead,
    OpLinkUse,
    OpDepthTop,
    OpEmitLoad
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_b;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic edge_ok;
    logic walk_ok;
    logic clear_done;
    logic cur_nil;
    logic take;
    logic link_ok;
    logic pend_empty;
    logic [1:0] mode;
  } dp_stat_t;

endpackage

// ----- rtl/core/gto_if.sv -----
// ============================================================================
// gto_in_if / gto_out_if / gto_cfg_if
// Valid-ready channels of the graph traversal block.
// ============================================================================
interface gto_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] node_a;
  logic [5:0] node_b;
  modport source (output valid, kind, node_a, node_b, input ready);
  modport sink   (input valid, kind, node_a, node_b, output ready);
endinterface

interface gto_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] visited_node;
  logic       last_visit;
  logic [1:0] status;
  modport source (output valid, visited_node, last_visit, status, input ready);
  modport sink   (input valid, visited_node, last_visit, status, output ready);
endinterface

interface gto_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/graph_traversal_order.sv -----
// An edge item writes and links a list entry at each end, then shows its result;
// a dropped edge goes straight to it. A traverse clears the visited marks, starts
// its walk, then reads each node's neighbor list from link memory; a waiting result
// holds it. Throughput: one item at a time; a new item is taken once its last result
// is gone. Reset (rst_n, synchronous): empties all neighbor lists, clears links in use,
// visited marks, the result valid and walk_mode; link memory is not cleared.
// ============================================================================
// graph_traversal_order
// Undirected graph store with depth-first, stack and breadth-first walks.
// ============================================================================
module graph_traversal_order
  import gto_pkg::*;
#(
  parameter int unsigned MAX_NODES = NodesDefault,
  parameter int unsigned MAX_LINKS = LinksDefault
) (
  input logic clk,
  input logic rst_n,
  gto_in_if.sink    in_ch,
  gto_out_if.source out_ch,
  gto_cfg_if.sink   cfg_ch
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             ov, olast, load;
  logic [NodeW-1:0] enode, onode;
  logic [1:0]       estat, ostat;

  assign cfg_ch.ready = in_ch.ready;

  gto_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(ov), .out_ready(out_ch.ready), .out_last(olast),
    .out_load(load), .cmd, .stat
  );

  gto_datapath #(.MAX_NODES(MAX_NODES), .MAX_LINKS(MAX_LINKS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_kind(in_ch.kind), .in_a(in_ch.node_a), .in_b(in_ch.node_b),
    .cfg_we(cfg_ch.valid && cfg_ch.ready), .cfg_data(cfg_ch.data),
    .emit_node(enode), .emit_status(estat)
  );

  // Result register: holds each transfer's payload until it is taken.
  gto_outbuf u_ob (
    .clk, .rst_n, .load, .node_in(enode), .status_in(estat),
    .node_out(onode), .status_out(ostat)
  );

  assign out_ch.valid        = ov;
  assign out_ch.last_visit   = olast;
  assign out_ch.visited_node = onode;
  assign out_ch.status       = ostat;

endmodule

// ----- rtl/core/gto_datapath.sv -----
// ============================================================================
// gto_datapath
// Link memory, list pointers, visited marks and the walk stack or queue.
// ============================================================================
module gto_datapath
  import gto_pkg::*;
#(
  parameter int unsigned MAX_NODES = NodesDefault,
  parameter int unsigned MAX_LINKS = LinksDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             in_kind,
  input  logic [NodeW-1:0] in_a,
  input  logic [NodeW-1:0] in_b,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data,
  output logic [NodeW-1:0] emit_node,
  output logic [1:0]       emit_status
);

  localparam int unsigned LW = $clog2(MAX_LINKS + 1);
  localparam int unsigned AW = $clog2(MAX_LINKS);
  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam logic [LW-1:0] Nil = LW'(MAX_LINKS);

  // Memories: link entries, per-node list ends, walk stack and cursors.
  logic [NodeW-1:0] tgt_mem [MAX_LINKS];
  logic [LW-1:0]    nxt_mem [MAX_LINKS];
  logic [LW-1:0]    head_mem [MAX_NODES];
  logic [LW-1:0]    tail_mem [MAX_NODES];
  logic [NodeW-1:0] pend_mem [MAX_NODES];
  logic [LW-1:0]    curs_mem [MAX_NODES];
  logic [MAX_NODES-1:0] list_ok_r;
  logic [MAX_NODES-1:0] mark_r;

  logic             kind_r;
  logic [NodeW-1:0] a_r, b_r;
  logic [1:0]       mode_r;
  logic [LW-1:0]    used_r;
  logic [LW-1:0]    hd_r, tl_r;
  logic [LW-1:0]    cur_r;
  logic [NodeW-1:0] tgt_r, node_r;
  logic [LW-1:0]    lnk_r;
  logic [CW-1:0]    top_r, qh_r;
  logic [NodeW-1:0] emit_r;
  logic [1:0]       est_r;
  logic             take_r;

  logic [NodeW-1:0] own;
  logic [NodeW-1:0] oth;
  logic             edge_ok, walk_ok, t_ok, room;
  logic [LW-1:0]    hd_v, tl_v;
  logic [NW-1:0]    cidx;

  assign own  = cmd.sel_b ? b_r : a_r;
  assign oth  = cmd.sel_b ? a_r : b_r;
  assign hd_v = list_ok_r[own[NW-1:0]] ? hd_r : Nil;
  assign tl_v = tl_r;
  assign edge_ok = (32'(a_r) < MAX_NODES) && (32'(b_r) < MAX_NODES)
                   && (32'(used_r) + 32'd2 <= MAX_LINKS);
  assign walk_ok = 32'(a_r) < MAX_NODES;
  assign room = (mode_r == ModeBreadth) ? (32'(top_r) < MAX_NODES)
                : (mode_r == ModeStack) ? (32'(top_r) < MAX_NODES)
                : (32'(top_r) < MAX_NODES);
  assign t_ok = (32'(tgt_r) < MAX_NODES) && !mark_r[tgt_r[NW-1:0]] && room;
  assign cidx = NW'(top_r - CW'(1));

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ModeDepth;
      used_r    <= '0;
      list_ok_r <= '0;
      mark_r    <= '0;
    end else begin
      if (cfg_we) mode_r <= cfg_data;
      if (cmd.op == OpEdgeLink) begin
        list_ok_r[own[NW-1:0]] <= 1'b1;
        used_r <= used_r + LW'(1);
      end
      if (cmd.op == OpClearMarks) mark_r <= '0;
      if (cmd.op == OpWalkStart) mark_r[a_r[NW-1:0]] <= 1'b1;
      if (cmd.op == OpLinkUse && t_ok) mark_r[tgt_r[NW-1:0]] <= 1'b1;
    end
  end

  // Memory ports and payload registers.
  always_ff @(posedge clk) begin
    hd_r <= head_mem[own[NW-1:0]];
    tl_r <= tail_mem[own[NW-1:0]];
    unique case (cmd.op)
      OpLoad: begin
        kind_r <= in_kind;
        a_r    <= in_a;
        b_r    <= in_b;
      end
      OpEdgeWrite: begin
        tgt_mem[used_r[AW-1:0]] <= oth;
        nxt_mem[used_r[AW-1:0]] <= Nil;
        est_r  <= StatusAdded;
        emit_r <= '0;
      end
      OpEdgeLink: begin
        if (hd_v == Nil) head_mem[own[NW-1:0]] <= used_r;
        else nxt_mem[tl_v[AW-1:0]] <= used_r;
        tail_mem[own[NW-1:0]] <= used_r;
      end
      OpEdgeHead: begin
        est_r  <= edge_ok ? StatusAdded : StatusDrop;
        emit_r <= '0;
      end
      OpWalkStart: begin
        pend_mem[0] <= a_r;
        top_r <= CW'(1);
        qh_r  <= '0;
        node_r <= a_r;
        if (mode_r == ModeStack || mode_r == ModeBreadth) begin
          top_r <= CW'(1);
        end else begin
          emit_r <= a_r;
          est_r  <= StatusVisit;
        end
      end
      OpPop: begin
        // Stack pops from the top, queue from the head.
        if (mode_r == ModeBreadth) begin
          node_r <= pend_mem[qh_r[NW-1:0]];
          qh_r   <= qh_r + CW'(1);
        end else begin
          node_r <= pend_mem[cidx];
          top_r  <= top_r - CW'(1);
        end
      end
      OpEmitLoad: begin
        emit_r <= node_r;
        est_r  <= StatusVisit;
      end
      OpHeadRead: begin
        // Cursor for the node just entered or popped.
        cur_r <= list_ok_r[node_r[NW-1:0]] ? head_mem[node_r[NW-1:0]] : Nil;
      end
      OpDepthTop: begin
        cur_r <= curs_mem[cidx];
      end
      OpLinkRead: begin
        tgt_r <= tgt_mem[cur_r[AW-1:0]];
        lnk_r <= nxt_mem[cur_r[AW-1:0]];
      end
      OpLinkUse: begin
        take_r <= t_ok;
        cur_r  <= lnk_r;
        if (mode_r == ModeStack || mode_r == ModeBreadth) begin
          if (t_ok) begin
            pend_mem[top_r[NW-1:0]] <= tgt_r;
            top_r <= top_r + CW'(1);
          end
        end else begin
          curs_mem[cidx] <= lnk_r;
          if (t_ok) begin
            node_r <= tgt_r;
            emit_r <= tgt_r;
            est_r  <= StatusVisit;
            top_r  <= top_r + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    if (cmd.op == OpHeadRead && !(mode_r == ModeStack || mode_r == ModeBreadth))
      curs_mem[cidx] <= list_ok_r[node_r[NW-1:0]] ? head_mem[node_r[NW-1:0]] : Nil;
  end

  assign stat.kind       = kind_r;
  assign stat.edge_ok    = edge_ok;
  assign stat.walk_ok    = walk_ok;
  assign stat.clear_done = 1'b1;
  assign stat.cur_nil    = cur_r >= Nil;
  assign stat.take       = take_r;
  assign stat.link_ok    = t_ok;
  assign stat.pend_empty = (mode_r == ModeBreadth) ? (qh_r == top_r) : (top_r == '0);
  assign stat.mode       = mode_r;
  assign emit_node   = emit_r;
  assign emit_status = est_r;

endmodule

// ----- rtl/core/gto_ctrl.sv -----
// ============================================================================
// gto_ctrl
// Sequencer for edge insertion and the three walk orders.
// ============================================================================
module gto_ctrl
  import gto_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  output logic     out_load,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_DEC, S_EH_A, S_EW_A, S_EL_A, S_EH_B, S_EW_B, S_EL_B,
    S_EDGE_OUT, S_CLEAR, S_DSTART, S_DHEAD, S_DTOP, S_DREAD, S_DUSE, S_DPOP,
    S_SPOP, S_SEMIT, S_SHEAD, S_SREAD, S_SUSE, S_HOLD, S_DONE
  } state_t;

  // A visit is held back until the next one is known so that the last
  // visit can be flagged. Each released visit is copied into the result
  // register in the cycle that out_load is high.
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   have_r, have_nxt, ov_r, ov_nxt, last_r, last_nxt;
  dp_op_t op;
  logic   selb;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_last  = last_r;
  assign cmd.op    = op;
  assign cmd.sel_b = selb;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    have_nxt  = have_r;
    ov_nxt    = ov_r;
    last_nxt  = last_r;
    op        = OpNone;
    selb      = 1'b0;
    out_load  = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        op = OpLoad;
        state_nxt = S_DEC;
      end
      S_LOAD: state_nxt = S_DEC;
      S_DEC: begin
        if (stat.kind == KindEdge) begin
          state_nxt = stat.edge_ok ? S_EH_A : S_EDGE_OUT;
          op = OpEdgeHead;
        end else if (!stat.walk_ok) state_nxt = S_IDLE;
        else state_nxt = S_CLEAR;
      end
      S_EH_A: begin op = OpEdgeWrite; state_nxt = S_EL_A; end
      S_EL_A: begin op = OpEdgeLink;  state_nxt = S_EH_B; end
      S_EH_B: begin selb = 1'b1; state_nxt = S_EW_B; end
      S_EW_B: begin selb = 1'b1; op = OpEdgeWrite; state_nxt = S_EL_B; end
      S_EL_B: begin selb = 1'b1; op = OpEdgeLink;  state_nxt = S_EDGE_OUT; end
      S_EDGE_OUT: if (!ov_r) begin
        out_load = 1'b1; ov_nxt = 1'b1; last_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        op = OpClearMarks;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        op = OpWalkStart;
        have_nxt = 1'b0;
        if (stat.mode == ModeStack || stat.mode == ModeBreadth) state_nxt = S_SPOP;
        else begin have_nxt = 1'b1; state_nxt = S_DHEAD; end
      end
      // Depth-first preorder: cursor per stack level.
      S_DHEAD: begin op = OpHeadRead; state_nxt = S_DTOP; end
      S_DTOP: begin
        if (stat.pend_empty) state_nxt = S_DONE;
        else begin op = OpDepthTop; state_nxt = S_DREAD; end
      end
      S_DREAD: begin
        if (stat.cur_nil) state_nxt = S_DPOP;
        else begin op = OpLinkRead; state_nxt = S_DUSE; end
      end
      S_DUSE: if (!ov_r || out_ready) begin
        // A new visit replaces the held one, which goes out now.
        if (have_r && stat.link_ok) begin
          out_load = 1'b1; ov_nxt = 1'b1; last_nxt = 1'b0;
        end
        op = OpLinkUse;
        state_nxt = S_HOLD;
        ret_nxt = S_DHEAD;
      end
      S_DPOP: begin op = OpPop; state_nxt = S_DTOP; end
      // Stack and breadth-first orders.
      S_SPOP: begin
        if (stat.pend_empty) state_nxt = S_DONE;
        else if (!have_r || !ov_r || out_ready) begin
          if (have_r) begin out_load = 1'b1; ov_nxt = 1'b1; last_nxt = 1'b0; end
          op = OpPop; state_nxt = S_SEMIT;
        end
      end
      S_SEMIT: begin op = OpEmitLoad; have_nxt = 1'b1; state_nxt = S_SHEAD; end
      S_SHEAD: begin op = OpHeadRead; state_nxt = S_SREAD; end
      S_SREAD: begin
        if (stat.cur_nil) state_nxt = S_SPOP;
        else begin op = OpLinkRead; state_nxt = S_SUSE; end
      end
      S_SUSE: begin op = OpLinkUse; state_nxt = S_SREAD; end
      S_HOLD: state_nxt = stat.take ? ret_r : S_DREAD;
      S_DONE: if (!ov_r) begin
        out_load = 1'b1; ov_nxt = 1'b1; last_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      have_r  <= 1'b0;
      ov_r    <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      have_r  <= have_nxt;
      ov_r    <= ov_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ----- rtl/core/gto_outbuf.sv -----
// ============================================================================
// gto_outbuf
// Result register: captures a released visit or an edge result when load is
// high and holds it on the output until the next load.
// ============================================================================
module gto_outbuf
  import gto_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [NodeW-1:0] node_in,
  input  logic [1:0]       status_in,
  output logic [NodeW-1:0] node_out,
  output logic [1:0]       status_out
);

  logic [NodeW-1:0] node_r;
  logic [1:0]       status_r;

  // Capture when the controller raises a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= StatusVisit;
      node_r   <= '0;
    end else if (load) begin
      node_r   <= node_in;
      status_r <= status_in;
    end
  end

  assign node_out   = node_r;
  assign status_out = status_r;

endmodule

// ----- rtl/core/gto_checker.sv -----
// ============================================================================
// gto_checker
// Port-level checks for the graph traversal block.
// ============================================================================
module gto_checker
  import gto_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] visited_node,
  input logic [1:0] status
);

  // A stalled result stays valid and keeps its visited node.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(visited_node))
    else $error("result changed while stalled");

  // No new item is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during stall");

  // Status never shows the unused code.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3)
    else $error("bad status code");

  // An accepted item is not answered in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("latency violated");

endmodule

bind graph_traversal_order gto_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .visited_node(out_ch.visited_node), .status(out_ch.status)
);
